// File: rtl/v3mu_pkg.sv
// shared types, constants and saturation helpers for the vector3 math unit
`timescale 1ns / 1ps
package v3mu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int LANES         = 3;
	localparam int LANE_W        = 65;
	localparam int SUM_W         = 66;
	localparam int RAD_W         = 64;
	localparam int ROOT_W        = 32;
	localparam int DEN_W         = 32;
	localparam int KIND_W        = 3;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_CROSS  = 3'd0,
		KIND_SCALE  = 3'd1,
		KIND_DIVIDE = 3'd2,
		KIND_DOT    = 3'd3,
		KIND_MAG    = 3'd4,
		KIND_NORM   = 3'd5
	} kind_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     clip;
	} sat_t;

	typedef struct packed {
		logic [KIND_W-1:0]            kind;
		logic [LANES-1:0][DATA_W-1:0] a;
		logic [DATA_W-1:0]            s;
		sat_t [LANES-1:0]             vec;
		sat_t                         dot;
	} sq_tag_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		sat_t [LANES-1:0]  vec;
		sat_t              dot;
		logic [ROOT_W-1:0] root;
	} dv_tag_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rx;
		logic signed [DATA_W-1:0] ry;
		logic signed [DATA_W-1:0] rz;
		logic signed [DATA_W-1:0] so;
		logic                     sat;
	} res_t;

	function automatic sat_t sat66(input logic signed [SUM_W-1:0] v);
		sat_t r;
		r.clip = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
		r.val  = r.clip ? (v[SUM_W-1] ? Q_MIN : Q_MAX) : v[DATA_W-1:0];
		return r;
	endfunction

	function automatic sat_t sat_mag(input logic neg, input logic [63:0] q);
		sat_t r;
		if (neg) begin
			r.clip = q > 64'h0000_0000_8000_0000;
			r.val  = r.clip ? Q_MIN : (~q[DATA_W-1:0]) + 32'd1;
		end else begin
			r.clip = q > 64'h0000_0000_7FFF_FFFF;
			r.val  = r.clip ? Q_MAX : q[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/v3mu_lane.sv
// one component lane: two multipliers and the cross difference
`timescale 1ns / 1ps
module v3mu_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [v3mu_pkg::KIND_W-1:0]         kind,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  a_own,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  b_own,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  a_n1,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  a_n2,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  b_n1,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  b_n2,
	input  logic signed [v3mu_pkg::DATA_W-1:0]  s,
	output logic signed [v3mu_pkg::LANE_W-1:0]  t
);
	import v3mu_pkg::*;

	logic signed [DATA_W-1:0]   op0a, op0b, op1a, op1b;
	logic signed [2*DATA_W-1:0] p0_s1, p1_s1;
	logic                       cross_s1;
	logic signed [LANE_W-1:0]   t_s2;

	always_comb begin
		op0a = a_own;
		op0b = s;
		op1a = b_n1;
		op1b = a_n2;
		unique case (kind)
			KIND_CROSS: begin
				op0a = a_n1;
				op0b = b_n2;
			end
			KIND_SCALE, KIND_DIVIDE: op0b = s;
			KIND_DOT: op0b = b_own;
			KIND_MAG, KIND_NORM: op0b = a_own;
			default: op0b = s;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1    <= op0a * op0b;
			p1_s1    <= op1a * op1b;
			cross_s1 <= kind == KIND_CROSS;
			t_s2     <= cross_s1 ? {p0_s1[2*DATA_W-1], p0_s1} - {p1_s1[2*DATA_W-1], p1_s1}
			                     : {p0_s1[2*DATA_W-1], p0_s1};
		end
	end

	assign t = t_s2;

endmodule

// File: rtl/v3mu_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module v3mu_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [v3mu_pkg::RAD_W-1:0]  rad,
	input  v3mu_pkg::sq_tag_t           tag_in,
	output logic                        out_vld,
	output logic [v3mu_pkg::ROOT_W-1:0] root,
	output v3mu_pkg::sq_tag_t           tag_out
);
	import v3mu_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic              vld_s  [1:ROOT_W];
	logic [REM_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [RAD_W-1:0]  rad_s  [1:ROOT_W];
	sq_tag_t           tag_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              c_vld;
		logic [REM_W-1:0]  c_rem;
		logic [ROOT_W-1:0] c_root;
		logic [RAD_W-1:0]  c_rad;
		sq_tag_t           c_tag;
		logic [REM_W-1:0]  r_sh, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign c_vld  = in_vld;
			assign c_rem  = '0;
			assign c_root = '0;
			assign c_rad  = rad;
			assign c_tag  = tag_in;
		end else begin : g_next
			assign c_vld  = vld_s[k];
			assign c_rem  = rem_s[k];
			assign c_root = root_s[k];
			assign c_rad  = rad_s[k];
			assign c_tag  = tag_s[k];
		end

		assign r_sh  = {c_rem[REM_W-3:0], c_rad[RAD_W-1-2*k -: 2]};
		assign trial = {1'b0, c_root, 2'b01};
		assign ge    = r_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? r_sh - trial : r_sh;
				root_s[k+1] <= {c_root[ROOT_W-2:0], ge};
				rad_s[k+1]  <= c_rad;
				tag_s[k+1]  <= c_tag;
			end
		end
	end

	assign out_vld = vld_s[ROOT_W];
	assign root    = root_s[ROOT_W];
	assign tag_out = tag_s[ROOT_W];

endmodule

// File: rtl/v3mu_div.sv
// pipelined restoring divider, three lanes sharing one divisor
`timescale 1ns / 1ps
module v3mu_div #(
	parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    en,
	input  logic                                                    in_vld,
	input  logic [v3mu_pkg::DEN_W-1:0]                              den,
	input  logic [v3mu_pkg::LANES-1:0][v3mu_pkg::DATA_W-1:0]        mag,
	input  logic [v3mu_pkg::LANES-1:0]                              neg,
	input  v3mu_pkg::dv_tag_t                                       tag_in,
	output logic                                                    out_vld,
	output logic [v3mu_pkg::LANES-1:0][v3mu_pkg::DATA_W+FRAC_BITS-1:0] q,
	output logic [v3mu_pkg::LANES-1:0]                              neg_out,
	output v3mu_pkg::dv_tag_t                                       tag_out
);
	import v3mu_pkg::*;

	localparam int NUM_W = DATA_W + FRAC_BITS;

	logic                               vld_s [1:NUM_W];
	logic [LANES-1:0][DEN_W-1:0]        rem_s [1:NUM_W];
	logic [LANES-1:0][NUM_W-1:0]        q_s   [1:NUM_W];
	logic [LANES-1:0][NUM_W-1:0]        num_s [1:NUM_W];
	logic [LANES-1:0]                   neg_s [1:NUM_W];
	logic [DEN_W-1:0]                   den_s [1:NUM_W];
	dv_tag_t                            tag_s [1:NUM_W];

	for (genvar j = 0; j < NUM_W; j++) begin : g_stage
		logic                        c_vld;
		logic [LANES-1:0][DEN_W-1:0] c_rem, n_rem;
		logic [LANES-1:0][NUM_W-1:0] c_q, n_q, c_num;
		logic [LANES-1:0]            c_neg;
		logic [DEN_W-1:0]            c_den;
		dv_tag_t                     c_tag;

		if (j == 0) begin : g_first
			assign c_vld = in_vld;
			assign c_rem = '0;
			assign c_q   = '0;
			assign c_neg = neg;
			assign c_den = den;
			assign c_tag = tag_in;
			for (genvar l = 0; l < LANES; l++) begin : g_num
				assign c_num[l] = {mag[l], {FRAC_BITS{1'b0}}};
			end
		end else begin : g_next
			assign c_vld = vld_s[j];
			assign c_rem = rem_s[j];
			assign c_q   = q_s[j];
			assign c_num = num_s[j];
			assign c_neg = neg_s[j];
			assign c_den = den_s[j];
			assign c_tag = tag_s[j];
		end

		always_comb begin
			logic [DEN_W:0] r_sh;
			logic           ge;
			for (int l = 0; l < LANES; l++) begin
				r_sh     = {c_rem[l], c_num[l][NUM_W-1-j]};
				ge       = r_sh >= {1'b0, c_den};
				n_rem[l] = ge ? DEN_W'(r_sh - {1'b0, c_den}) : r_sh[DEN_W-1:0];
				n_q[l]   = {c_q[l][NUM_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= n_rem;
				q_s[j+1]   <= n_q;
				num_s[j+1] <= c_num;
				neg_s[j+1] <= c_neg;
				den_s[j+1] <= c_den;
				tag_s[j+1] <= c_tag;
			end
		end
	end

	assign out_vld = vld_s[NUM_W];
	assign q       = q_s[NUM_W];
	assign neg_out = neg_s[NUM_W];
	assign tag_out = tag_s[NUM_W];

endmodule

// File: rtl/vector3_math_unit_core.sv
// top level of the vector3 math unit: lanes, merge, root, divide and output buffer
`timescale 1ns / 1ps
// Signed Q fixed-point 3D vector unit: cross, scale, divide by scalar, dot,
// magnitude and normalize. One request is taken every clock cycle while
// req_stall is low. Each result passes through the two multiply stages and
// the merge adder, the 32-stage square root pipeline, the one-bit-per-stage
// divider and the output register.
// Every operation travels the full pipeline so results leave in request
// order. A two-entry output buffer lets the pipeline keep moving after
// res_stall rises until a second result is waiting; req_stall is registered.
module vector3_math_unit_core #(
	parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  kind,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic        saturated
);
	import v3mu_pkg::*;

	localparam int NUM_W = DATA_W + FRAC_BITS;

	logic en;
	logic signed [DATA_W-1:0] a_v [LANES];
	logic signed [DATA_W-1:0] b_v [LANES];
	logic signed [LANE_W-1:0] t_w [LANES];
	logic signed [SUM_W-1:0]  te  [LANES];

	logic                         vld_s1, vld_s2, vld_s3;
	logic [KIND_W-1:0]            kind_s1, kind_s2, kind_s3;
	logic [LANES-1:0][DATA_W-1:0] a_s1, a_s2, a_s3;
	logic [DATA_W-1:0]            s_s1, s_s2, s_s3;
	logic signed [SUM_W-1:0]      sum_s3;
	sat_t [LANES-1:0]             vec_s3;

	sq_tag_t           sq_in, sq_out;
	logic              sq_vld;
	logic [ROOT_W-1:0] root_w;

	dv_tag_t                      dv_in, dv_out;
	logic [DEN_W-1:0]             den, den_raw, smag;
	logic [LANES-1:0][DATA_W-1:0] dmag;
	logic [LANES-1:0]             dneg, qneg;
	logic [LANES-1:0][NUM_W-1:0]  quo;
	logic                         pv;
	logic                         is_div;

	sat_t [LANES-1:0] qs;
	sat_t             ms;
	res_t             fin, res_q, sk_q;
	logic             res_vld_q, sk_vld_q;

	assign en        = !sk_vld_q;
	assign req_stall = sk_vld_q;

	assign a_v[0] = ax;
	assign a_v[1] = ay;
	assign a_v[2] = az;
	assign b_v[0] = bx;
	assign b_v[1] = by;
	assign b_v[2] = bz;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		v3mu_lane u_lane (
			.clk   (clk),
			.en    (en),
			.kind  (kind),
			.a_own (a_v[i]),
			.b_own (b_v[i]),
			.a_n1  (a_v[(i+1)%LANES]),
			.a_n2  (a_v[(i+2)%LANES]),
			.b_n1  (b_v[(i+1)%LANES]),
			.b_n2  (b_v[(i+2)%LANES]),
			.s     (scalar_in),
			.t     (t_w[i])
		);
		assign te[i] = {t_w[i][LANE_W-1], t_w[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			a_s1    <= {az, ay, ax};
			s_s1    <= scalar_in;
			kind_s2 <= kind_s1;
			a_s2    <= a_s1;
			s_s2    <= s_s1;
			kind_s3 <= kind_s2;
			a_s3    <= a_s2;
			s_s3    <= s_s2;
			sum_s3  <= te[0] + te[1] + te[2];
			for (int i = 0; i < LANES; i++) begin
				vec_s3[i] <= sat66(te[i] >>> FRAC_BITS);
			end
		end
	end

	always_comb begin
		sq_in.kind = kind_s3;
		sq_in.a    = a_s3;
		sq_in.s    = s_s3;
		sq_in.vec  = vec_s3;
		sq_in.dot  = sat66(sum_s3 >>> FRAC_BITS);
	end

	v3mu_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.rad     (sum_s3[RAD_W-1:0]),
		.tag_in  (sq_in),
		.out_vld (sq_vld),
		.root    (root_w),
		.tag_out (sq_out)
	);

	always_comb begin
		is_div  = sq_out.kind == KIND_DIVIDE;
		smag    = sq_out.s[DATA_W-1] ? (~sq_out.s) + 32'd1 : sq_out.s;
		den_raw = is_div ? smag : root_w;
		den     = (den_raw == '0) ? DEN_W'(1) : den_raw;
		for (int i = 0; i < LANES; i++) begin
			dmag[i] = sq_out.a[i][DATA_W-1] ? (~sq_out.a[i]) + 32'd1 : sq_out.a[i];
			dneg[i] = sq_out.a[i][DATA_W-1] ^ (is_div & sq_out.s[DATA_W-1]);
		end
		dv_in.kind = sq_out.kind;
		dv_in.vec  = sq_out.vec;
		dv_in.dot  = sq_out.dot;
		dv_in.root = root_w;
	end

	v3mu_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.den     (den),
		.mag     (dmag),
		.neg     (dneg),
		.tag_in  (dv_in),
		.out_vld (pv),
		.q       (quo),
		.neg_out (qneg),
		.tag_out (dv_out)
	);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			qs[i] = sat_mag(qneg[i], 64'(quo[i]));
		end
		ms  = sat_mag(1'b0, 64'(dv_out.root));
		fin = '0;
		unique case (dv_out.kind)
			KIND_CROSS, KIND_SCALE: begin
				fin.rx  = dv_out.vec[0].val;
				fin.ry  = dv_out.vec[1].val;
				fin.rz  = dv_out.vec[2].val;
				fin.sat = dv_out.vec[0].clip | dv_out.vec[1].clip | dv_out.vec[2].clip;
			end
			KIND_DIVIDE: begin
				fin.rx  = qs[0].val;
				fin.ry  = qs[1].val;
				fin.rz  = qs[2].val;
				fin.sat = qs[0].clip | qs[1].clip | qs[2].clip;
			end
			KIND_DOT: begin
				fin.so  = dv_out.dot.val;
				fin.sat = dv_out.dot.clip;
			end
			KIND_MAG: begin
				fin.so  = ms.val;
				fin.sat = ms.clip;
			end
			KIND_NORM: begin
				fin.rx  = qs[0].val;
				fin.ry  = qs[1].val;
				fin.rz  = qs[2].val;
				fin.so  = ms.val;
				fin.sat = qs[0].clip | qs[1].clip | qs[2].clip | ms.clip;
			end
			default: fin = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (res_vld_q && res_stall) begin
			if (en && pv) begin
				sk_vld_q <= 1'b1;
			end
		end else if (sk_vld_q) begin
			res_vld_q <= 1'b1;
			sk_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld_q && res_stall) begin
			if (en && pv) begin
				sk_q <= fin;
			end
		end else begin
			res_q <= sk_vld_q ? sk_q : fin;
		end
	end

	assign res_valid  = res_vld_q;
	assign rx         = res_q.rx;
	assign ry         = res_q.ry;
	assign rz         = res_q.rz;
	assign scalar_out = res_q.so;
	assign saturated  = res_q.sat;

endmodule

// File: tb/vector3_math_unit_core_tb.sv
// self-checking testbench for the vector3 math unit core with random flow control
`timescale 1ns / 1ps
module vector3_math_unit_core_tb;
	import v3mu_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] ax, ay, az, bx, by, bz, s;
		bit                 typed;
		res_t               res;
	} request_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [2:0] kind;
	logic signed [31:0] ax, ay, az, bx, by, bz, scalar_in;
	logic res_valid;
	logic res_stall;
	logic signed [31:0] rx, ry, rz, scalar_out;
	logic saturated;

	res_t expected_results[$];
	int mismatches = 0;
	int accepted = 0;

	vector3_math_unit_core DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.scalar_in(scalar_in),
		.res_valid(res_valid), .res_stall(res_stall),
		.rx(rx), .ry(ry), .rz(rz), .scalar_out(scalar_out), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] clip66(input logic signed [65:0] v, inout bit flag);
		if (v > 66'sd2147483647) begin
			flag = 1;
			return Q_MAX;
		end
		if (v < -66'sd2147483648) begin
			flag = 1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] clip_mag(input bit neg, input logic [63:0] q,
			inout bit flag);
		if (neg) begin
			if (q > 64'h8000_0000) begin
				flag = 1;
				return Q_MIN;
			end
			return -q[31:0];
		end
		if (q > 64'h7FFF_FFFF) begin
			flag = 1;
			return Q_MAX;
		end
		return q[31:0];
	endfunction

	function automatic logic signed [65:0] wide_mul(input logic signed [31:0] p,
			input logic signed [31:0] q);
		logic signed [65:0] pw, qw;
		pw = p;
		qw = q;
		return pw * qw;
	endfunction

	function automatic logic signed [31:0] cross_lane(input logic signed [31:0] p, q, r, s,
			inout bit flag);
		return clip66((wide_mul(p, q) - wide_mul(r, s)) >>> FRAC, flag);
	endfunction

	function automatic logic signed [31:0] fixed_quot(input logic signed [33:0] num,
			input logic [32:0] den, inout bit flag);
		logic [63:0] mag, d;
		mag = (num < 0) ? 64'(-num) : 64'(num);
		d = (den == 0) ? 64'd1 : 64'(den);
		return clip_mag(num < 0, (mag << FRAC) / d, flag);
	endfunction

	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic res_t vector_result(input request_row_t t);
		res_t r;
		bit flag;
		logic [32:0] m;
		logic [63:0] sq, root;
		logic signed [33:0] nx, ny, nz;
		r = '0;
		flag = 0;
		case (t.kind)
			KIND_CROSS: begin
				r.rx = cross_lane(t.ay, t.bz, t.by, t.az, flag);
				r.ry = cross_lane(t.az, t.bx, t.bz, t.ax, flag);
				r.rz = cross_lane(t.ax, t.by, t.bx, t.ay, flag);
			end
			KIND_SCALE: begin
				r.rx = clip66(wide_mul(t.ax, t.s) >>> FRAC, flag);
				r.ry = clip66(wide_mul(t.ay, t.s) >>> FRAC, flag);
				r.rz = clip66(wide_mul(t.az, t.s) >>> FRAC, flag);
			end
			KIND_DIVIDE: begin
				nx = t.ax;
				ny = t.ay;
				nz = t.az;
				m = (t.s < 0) ? 33'(-34'(t.s)) : 33'(t.s);
				if (t.s < 0) begin
					nx = -nx;
					ny = -ny;
					nz = -nz;
				end
				r.rx = fixed_quot(nx, m, flag);
				r.ry = fixed_quot(ny, m, flag);
				r.rz = fixed_quot(nz, m, flag);
			end
			KIND_DOT:
				r.so = clip66((wide_mul(t.ax, t.bx) + wide_mul(t.ay, t.by)
					+ wide_mul(t.az, t.bz)) >>> FRAC, flag);
			KIND_MAG, KIND_NORM: begin
				sq = 64'(wide_mul(t.ax, t.ax)) + 64'(wide_mul(t.ay, t.ay))
					+ 64'(wide_mul(t.az, t.az));
				root = floor_root(sq);
				r.so = clip_mag(0, root, flag);
				if (t.kind == KIND_NORM) begin
					r.rx = fixed_quot(t.ax, root[32:0], flag);
					r.ry = fixed_quot(t.ay, root[32:0], flag);
					r.rz = fixed_quot(t.az, root[32:0], flag);
				end
			end
			default: ;
		endcase
		r.sat = flag;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h (request count %0d)", field, got, want,
			accepted);
		mismatches++;
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("res_valid", 32'd1, 32'd0);
			end else begin
				e = expected_results.pop_front();
				if (rx !== e.rx) report_mismatch("rx", rx, e.rx);
				if (ry !== e.ry) report_mismatch("ry", ry, e.ry);
				if (rz !== e.rz) report_mismatch("rz", rz, e.rz);
				if (scalar_out !== e.so) report_mismatch("scalar_out", scalar_out, e.so);
				if (saturated !== e.sat)
					report_mismatch("saturated", 32'(saturated), 32'(e.sat));
			end
		end
	end

	// receiver flow control, with one long hold-off once traffic is flowing
	initial begin
		int seg, mode;
		bit held;
		res_stall = 1'b0;
		held = 0;
		forever begin
			if (!held && accepted > 500) begin
				held = 1;
				repeat (400) @(negedge clk) res_stall = 1'b1;
			end
			seg = $urandom_range(20, 200);
			mode = $urandom_range(0, 2);
			repeat (seg) @(negedge clk)
				res_stall = (mode == 0) ? 1'b0 :
					(mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 1);
		end
	end

	function automatic logic signed [31:0] pick_val();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2, 3: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			4: return 0;
			default: return $urandom;
		endcase
	endfunction

	int burst_left = 0;

	task automatic send_request(input request_row_t t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			@(negedge clk) req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		req_valid = 1'b1;
		kind = t.kind;
		ax = t.ax; ay = t.ay; az = t.az;
		bx = t.bx; by = t.by; bz = t.bz;
		scalar_in = t.s;
		do @(posedge clk); while (req_stall);
		expected_results.push_back(t.typed ? t.res : vector_result(t));
		accepted++;
	endtask

	request_row_t directed_rows[] = '{
		'{KIND_NORM, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1'b0}},
		'{KIND_MAG, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1'b0}},
		'{KIND_SPARE6, Q_MAX, Q_MIN, 5, 7, 9, 11, 3, 1, '{0, 0, 0, 0, 1'b0}},
		'{KIND_SPARE7, -1, -1, -1, -1, -1, -1, -1, 1, '{0, 0, 0, 0, 1'b0}},
		'{KIND_SCALE, 3, -7, 11, 0, 0, 0, ONE, 1, '{3, -7, 11, 0, 1'b0}},
		'{KIND_DIVIDE, 3, -7, 11, 0, 0, 0, ONE, 1, '{3, -7, 11, 0, 1'b0}},
		'{KIND_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 1, '{0, 0, 0, Q_MAX, 1'b1}},
		'{KIND_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0, 1, '{0, 0, 0, Q_MIN, 1'b1}},
		'{KIND_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 1, '{0, 0, ONE, 0, 1'b0}},
		'{KIND_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_CROSS, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_SCALE, Q_MAX, Q_MIN, -1, 0, 0, 0, Q_MIN, 0, '{0, 0, 0, 0, 0}},
		'{KIND_SCALE, Q_MIN, 1, -1, 0, 0, 0, -1, 0, '{0, 0, 0, 0, 0}},
		'{KIND_DIVIDE, Q_MAX, Q_MIN, 1, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_DIVIDE, Q_MIN, Q_MAX, -5, 0, 0, 0, Q_MIN, 0, '{0, 0, 0, 0, 0}},
		'{KIND_DIVIDE, Q_MIN, ONE, 0, 0, 0, 0, -ONE, 0, '{0, 0, 0, 0, 0}},
		'{KIND_MAG, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_NORM, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_NORM, 1, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_NORM, -ONE, 2 * ONE, -2 * ONE, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}},
		'{KIND_DOT, ONE, -ONE, 3, -2, 5, Q_MIN, 0, 0, '{0, 0, 0, 0, 0}}
	};

	initial begin
		request_row_t t;
		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = KIND_CROSS;
		{ax, ay, az, bx, by, bz, scalar_in} = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		foreach (directed_rows[i]) send_request(directed_rows[i]);
		repeat (2000) begin
			t.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			t.ax = pick_val(); t.ay = pick_val(); t.az = pick_val();
			t.bx = pick_val(); t.by = pick_val(); t.bz = pick_val();
			t.s = pick_val();
			t.typed = 0;
			send_request(t);
		end
		@(negedge clk) req_valid = 1'b0;
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
rtl/v3mu_pkg.sv
rtl/v3mu_lane.sv
rtl/v3mu_sqrt.sv
rtl/v3mu_div.sv
rtl/vector3_math_unit_core.sv
tb/vector3_math_unit_core_tb.sv
